FILE: rtl/adtc_pkg.sv
// adtc_pkg: shared types, constants and the color wheel for the
// autoranging distance-to-color block. No dependencies.

package adtc_pkg;

  localparam int DIST_W       = 16;
  localparam int COLOR_W      = 8;
  localparam int POS_W        = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W    = $clog2(POS_W);

  localparam logic [DIST_W-1:0]  LIMIT_RESET = 16'd4000;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 16'hFFFF;
  localparam logic [POS_W-1:0]   POS_MAX     = 8'd255;
  localparam logic [POS_W-1:0]   SEG_ONE     = 8'd85;
  localparam logic [POS_W-1:0]   SEG_TWO     = 8'd170;
  localparam logic [COLOR_W-1:0] COLOR_FULL  = 8'd255;

  // one request handed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] reading;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] ah;
  } job_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  function automatic rgb_t wheel(input logic [POS_W-1:0] pos);
    rgb_t c;
    logic [POS_W-1:0] q;
    logic [COLOR_W-1:0] t;
    c = '0;
    if (pos < SEG_ONE) begin
      q = pos;
    end else if (pos < SEG_TWO) begin
      q = pos - SEG_ONE;
    end else begin
      q = pos - SEG_TWO;
    end
    t = COLOR_W'(q * 8'd3);
    if (pos < SEG_ONE) begin
      c.r = t;
      c.g = COLOR_FULL - t;
    end else if (pos < SEG_TWO) begin
      c.r = COLOR_FULL - t;
      c.b = t;
    end else begin
      c.g = t;
      c.b = COLOR_FULL - t;
    end
    return c;
  endfunction

endpackage

FILE: rtl/adtc_front.sv
// adtc_front: classifies readings, tracks the observed range and issues
// requests for changed distances. Depends on adtc_pkg.

module adtc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [adtc_pkg::DIST_W-1:0]  cfg_wr_data,
  input  logic                         accept,
  input  logic [adtc_pkg::DIST_W-1:0]  distance_mm,
  input  logic                         timed_out,
  output logic                         push,
  output adtc_pkg::job_t               job
);

  logic [adtc_pkg::DIST_W-1:0] limit;
  logic [adtc_pkg::DIST_W-1:0] last;
  logic [adtc_pkg::DIST_W-1:0] lo;
  logic [adtc_pkg::DIST_W-1:0] ah;
  logic [adtc_pkg::DIST_W-1:0] lo_next;
  logic [adtc_pkg::DIST_W-1:0] ah_next;
  logic                        in_range;

  assign in_range = !timed_out && (distance_mm <= limit);

  always_comb begin
    ah_next = ah;
    if (distance_mm >= ah) begin
      ah_next = (distance_mm != adtc_pkg::DIST_MAX) ? distance_mm + 16'd1
                                                    : adtc_pkg::DIST_MAX;
    end
    lo_next = (distance_mm < lo) ? distance_mm : lo;
  end

  assign push        = accept && in_range && (distance_mm != last);
  assign job.reading = distance_mm;
  assign job.lo      = lo_next;
  assign job.ah      = ah_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= adtc_pkg::LIMIT_RESET;
      last  <= '0;
      lo    <= adtc_pkg::DIST_MAX;
      ah    <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (accept && in_range) begin
        lo <= lo_next;
        ah <= ah_next;
      end
      if (push) begin
        last <= distance_mm;
      end
    end
  end

endmodule

FILE: rtl/adtc_fifo.sv
// adtc_fifo: short request queue between front and back.
// Depends on adtc_pkg.

module adtc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  adtc_pkg::job_t wr_job,
  input  logic           pop,
  output adtc_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  adtc_pkg::job_t                mem [adtc_pkg::QUEUE_DEPTH];
  logic [adtc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [adtc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [adtc_pkg::QCNT_W-1:0]   count;

  assign full   = (count == adtc_pkg::QCNT_W'(adtc_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == adtc_pkg::QPTR_W'(adtc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == adtc_pkg::QPTR_W'(adtc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/adtc_back.sv
// adtc_back: restoring divider for the wheel position, color wheel and
// output register. Depends on adtc_pkg.

module adtc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  adtc_pkg::job_t                job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adtc_pkg::COLOR_W-1:0]  red,
  output logic [adtc_pkg::COLOR_W-1:0]  green,
  output logic [adtc_pkg::COLOR_W-1:0]  blue
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                       state;
  logic [adtc_pkg::DIST_W-1:0]      rem;
  logic [adtc_pkg::DIST_W-1:0]      den;
  logic [adtc_pkg::POS_W-1:0]       quo;
  logic [adtc_pkg::DIV_CNT_W-1:0]   cnt;
  logic                             sat;
  logic [adtc_pkg::DIST_W:0]        shifted;
  logic                             fits;
  logic                             out_free;
  adtc_pkg::rgb_t                   color;

  assign sat      = (job.reading >= job.ah) || (job.ah <= job.lo);
  assign pop      = (state == S_IDLE) && !empty;
  assign shifted  = {rem, 1'b0};
  assign fits     = shifted >= {1'b0, den};
  assign out_free = !out_valid || !out_stall;
  assign color    = adtc_pkg::wheel(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cnt   <= '0;
            state <= sat ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == adtc_pkg::DIV_CNT_W'(adtc_pkg::POS_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      rem <= job.reading - job.lo;
      den <= job.ah - job.lo;
      quo <= sat ? adtc_pkg::POS_MAX : '0;
    end else if (state == S_DIV) begin
      rem <= fits ? adtc_pkg::DIST_W'(shifted - {1'b0, den})
                  : shifted[adtc_pkg::DIST_W-1:0];
      quo <= {quo[adtc_pkg::POS_W-2:0], fits};
    end
    if (state == S_DONE && out_free) begin
      red   <= color.r;
      green <= color.g;
      blue  <= color.b;
    end
  end

endmodule

FILE: rtl/autoranging_distance_to_color.sv
// autoranging_distance_to_color: top level, front classifier, request
// queue and divider back end. Depends on adtc_pkg, adtc_front, adtc_fifo, adtc_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | sink      | in_valid / in_stall  | distance_mm[15:0], timed_out
//   out     | source    | out_valid / out_stall| red, green, blue [7:0]
//   cfg     | sink      | cfg_wr_en            | cfg_wr_data[15:0] (limit)
//
// a reading is taken while in_valid is high and in_stall low; the front updates the
// range at once and queues a request only when the distance changed and is in range
// in the back end each request passes through a load, eight steps of the
// bit-per-cycle restoring divider and a wait to enter the output register
// (saturated positions skip the divider)
// in_stall rises only when the two-entry request queue is full
// out_stall holds the output register; the back end waits with a finished color
// rst is synchronous: limit returns to 4000, range and last distance clear

module autoranging_distance_to_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [adtc_pkg::DIST_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [adtc_pkg::DIST_W-1:0]   distance_mm,
  input  logic                          timed_out,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adtc_pkg::COLOR_W-1:0]  red,
  output logic [adtc_pkg::COLOR_W-1:0]  green,
  output logic [adtc_pkg::COLOR_W-1:0]  blue
);

  // queue handshake between the halves
  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  adtc_pkg::job_t wr_job;
  adtc_pkg::job_t rd_job;

  // front stalls only on a full queue, even for readings that would be dropped
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  adtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .distance_mm (distance_mm),
    .timed_out   (timed_out),
    .push        (push),
    .job         (wr_job)
  );

  adtc_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  adtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .job       (rd_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // no request enters a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("request pushed into full queue");

  // back end never takes from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("request popped from empty queue");

  // a timed-out reading never produces a request
  a_timeout_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && timed_out) |-> !push) else $error("timed-out reading queued");

  // a pop leaves the queue with room for the front
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> !full) else $error("queue still full after pop");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for autoranging_distance_to_color, driving readings
// through the valid/stall channels. Depends on adtc_pkg and the block's RTL.

module tb;

  // clock and stimulus-side signals, all known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [adtc_pkg::DIST_W-1:0]  cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [adtc_pkg::DIST_W-1:0]  distance_mm = '0;
  logic                         timed_out = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [adtc_pkg::COLOR_W-1:0] red;
  logic [adtc_pkg::COLOR_W-1:0] green;
  logic [adtc_pkg::COLOR_W-1:0] blue;

  // predicted state of the ranging logic
  logic [adtc_pkg::DIST_W-1:0]  limit_mm;
  logic [adtc_pkg::DIST_W-1:0]  last_mm;
  logic [adtc_pkg::DIST_W-1:0]  lowest_mm;
  logic [adtc_pkg::DIST_W-1:0]  above_top_mm;

  // colors still owed by the block, oldest first
  adtc_pkg::rgb_t pending_colors[$];

  // idle odds, in percent per cycle
  int send_idle_pct = 20;
  int recv_idle_pct = 57;

  int readings_sent  = 0;
  int colors_checked = 0;
  int mismatches     = 0;

  autoranging_distance_to_color uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .distance_mm (distance_mm),
    .timed_out   (timed_out),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // three-segment wheel: green to red, red to blue, blue back to green
  function automatic adtc_pkg::rgb_t wheel_color(input logic [adtc_pkg::POS_W-1:0] pos);
    adtc_pkg::rgb_t             c;
    logic [adtc_pkg::POS_W-1:0] ramp;
    c = '0;
    if (pos < adtc_pkg::SEG_ONE) begin
      ramp = pos * 8'd3;
      c.r  = ramp;
      c.g  = adtc_pkg::COLOR_FULL - ramp;
    end else if (pos < adtc_pkg::SEG_TWO) begin
      ramp = (pos - adtc_pkg::SEG_ONE) * 8'd3;
      c.r  = adtc_pkg::COLOR_FULL - ramp;
      c.b  = ramp;
    end else begin
      ramp = (pos - adtc_pkg::SEG_TWO) * 8'd3;
      c.g  = ramp;
      c.b  = adtc_pkg::COLOR_FULL - ramp;
    end
    return c;
  endfunction

  // update the range for one accepted reading; returns 1 when a color is due
  function automatic bit next_color(input logic [adtc_pkg::DIST_W-1:0] d, input logic tmo,
                                    output adtc_pkg::rgb_t c);
    logic [adtc_pkg::POS_W-1:0]    pos;
    logic [adtc_pkg::DIST_W+7:0]   scaled;
    logic [adtc_pkg::DIST_W:0]     span;
    logic [adtc_pkg::DIST_W+7:0]   quo;
    c = '0;
    // timed-out or out-of-limit readings leave everything untouched
    if (tmo || d > limit_mm) return 1'b0;
    // widen the range first, even for a repeated distance
    if (d >= above_top_mm) begin
      above_top_mm = (d != adtc_pkg::DIST_MAX) ? d + 16'd1 : adtc_pkg::DIST_MAX;
    end
    if (d < lowest_mm) lowest_mm = d;
    if (d == last_mm) return 1'b0;
    // at or past the saturated top, or an empty range: clamp to the wheel end
    if (d >= above_top_mm || above_top_mm <= lowest_mm) begin
      pos = adtc_pkg::POS_MAX;
    end else begin
      scaled = {d - lowest_mm, 8'h00};
      span   = above_top_mm - lowest_mm;
      quo    = scaled / span;
      pos    = (quo > adtc_pkg::POS_MAX) ? adtc_pkg::POS_MAX : quo[adtc_pkg::POS_W-1:0];
    end
    c = wheel_color(pos);
    last_mm = d;
    return 1'b1;
  endfunction

  // receiver side: random stall decided once per cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // every color taken by the receiver is matched against the oldest prediction
  always @(posedge clk) begin : check_colors
    adtc_pkg::rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $error("color %0d/%0d/%0d arrived with no request pending", red, green, blue);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (red !== want.r) begin
          $error("red: expected %0d, got %0d", want.r, red);
          mismatches++;
        end
        if (green !== want.g) begin
          $error("green: expected %0d, got %0d", want.g, green);
          mismatches++;
        end
        if (blue !== want.b) begin
          $error("blue: expected %0d, got %0d", want.b, blue);
          mismatches++;
        end
      end
    end
  end

  // one request on the input channel; entered and left on a falling edge
  task automatic send_reading(input logic [adtc_pkg::DIST_W-1:0] d, input logic tmo);
    adtc_pkg::rgb_t c;
    // sender idles at random before offering the request
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    distance_mm <= d;
    timed_out   <= tmo;
    // payload holds until a rising edge sees no stall
    do @(posedge clk); while (in_stall);
    readings_sent++;
    if (next_color(d, tmo, c)) pending_colors.push_back(c);
    @(negedge clk);
  endtask

  // stop sending and let the block run dry
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  // limit register write, only with the block idle
  task automatic set_limit(input logic [adtc_pkg::DIST_W-1:0] value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_mm  = value;
  endtask

  // hand-picked readings: ignore paths, first zero, repeats, wheel segment
  // boundaries, limit edges and saturation of the top of the range
  task automatic test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 57;
    // reset limit of 4000 still in force
    send_reading(16'd500, 1'b1);      // timed out
    send_reading(16'd4001, 1'b0);     // just past the limit
    send_reading(16'd0, 1'b0);        // first reading of zero matches reset last value
    send_reading(16'd0, 1'b0);
    send_reading(16'd1, 1'b0);
    send_reading(16'd4000, 1'b0);     // limit itself, range becomes 0..4000
    send_reading(16'd1328, 1'b0);     // last step of the first segment
    send_reading(16'd1329, 1'b0);     // first step of the second
    send_reading(16'd2656, 1'b0);
    send_reading(16'd2657, 1'b0);     // into the third segment
    send_reading(16'd2657, 1'b0);     // repeat, no color
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'd3500, 1'b0);
    // limit at zero: only zero gets through
    set_limit(16'd0);
    send_reading(16'd0, 1'b0);
    send_reading(16'd1, 1'b0);
    send_reading(16'd0, 1'b0);
    // full limit: the top of the range saturates instead of wrapping
    set_limit(adtc_pkg::DIST_MAX);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'hFFFE, 1'b0);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'h8000, 1'b0);
    send_reading(16'h7FFF, 1'b1);
    send_reading(16'h0001, 1'b0);
    drain_block();
  endtask

  // random readings under one limit: mostly in range, with timeouts,
  // repeats, out-of-limit values and extremes mixed in
  task automatic test_random_readings(input int count, input int s_pct, input int r_pct,
                                      input logic [adtc_pkg::DIST_W-1:0] lim);
    logic [adtc_pkg::DIST_W-1:0] d;
    logic [adtc_pkg::DIST_W-1:0] prev;
    logic                        tmo;
    int                          pick;
    set_limit(lim);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    prev = '0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      tmo  = 1'b0;
      if (pick < 8) begin
        d   = 16'($urandom);
        tmo = 1'b1;
      end else if (pick < 15) begin
        d = prev;
      end else if (pick < 22) begin
        d = (lim == adtc_pkg::DIST_MAX) ? adtc_pkg::DIST_MAX
                                        : 16'($urandom_range(lim + 1, adtc_pkg::DIST_MAX));
      end else if (pick < 27) begin
        case ($urandom_range(0, 2))
          0:       d = '0;
          1:       d = lim;
          default: d = adtc_pkg::DIST_MAX;
        endcase
      end else begin
        d = 16'($urandom_range(0, lim));
      end
      send_reading(d, tmo);
      prev = d;
    end
    drain_block();
  endtask

  // watchdog for a hung handshake
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    limit_mm     = adtc_pkg::LIMIT_RESET;
    last_mm      = '0;
    lowest_mm    = adtc_pkg::DIST_MAX;
    above_top_mm = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    // slow receiver, then slow sender, then both back to back
    test_random_readings(625, 20, 57, 16'($urandom_range(2000, 65533)));
    test_random_readings(625, 57, 20, 16'd65534);
    test_random_readings(625, 0, 0, adtc_pkg::DIST_MAX);

    drain_block();
    $display("%0d readings offered, %0d colors compared", readings_sent, colors_checked);
    $display("limits: reset value, zero, mid-range, 65534 and 65535, idling on each side");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
